// ===== hdl/ttl_pkg.sv =====
// ----------------------------------------------------------------------------
// ttl_pkg
// Shared types and constants of the TTL cache table.
// ----------------------------------------------------------------------------
package ttl_pkg;

   localparam int ENTRIES    = 8;
   localparam int SLOT_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int COUNT_W    = $clog2(ENTRIES + 1);
   localparam int KEY_W      = 64;
   localparam int TTL_W      = 32;
   localparam int DATA_W     = 32;
   localparam int CMD_W      = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 80;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_LOOKUP = 2'd2,
      CMD_TICK   = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type             command;
      logic [KEY_W-1:0]    key;
      logic [TTL_W-1:0]    ttl;
      logic [DATA_W-1:0]   data;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_TICK_DEC,
      ST_TICK_SWEEP,
      ST_EVICT_SCAN,
      ST_EVICT_MOVE,
      ST_WRITE,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/ttl_front.sv =====
// ----------------------------------------------------------------------------
// ttl_front
// Accepts command items, decodes them and queues them for the engine.
// ----------------------------------------------------------------------------
module ttl_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [ttl_pkg::REQ_DATA_W-1:0] in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output ttl_pkg::item_type             out_item
);
   localparam int PTR_W = $clog2(ttl_pkg::QUEUE_DEPTH);

   ttl_pkg::item_type q_ff [ttl_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]   cnt_ff, cnt_in;
   ttl_pkg::item_type dec;
   logic push, pop;

   always_comb begin
      dec.command = ttl_pkg::cmd_type'(in_data[1:0]);
      dec.key     = in_data[65:2];
      dec.ttl     = in_data[97:66];
      dec.data    = in_data[129:98];
   end

   assign in_ready  = (cnt_ff != (PTR_W+1)'(ttl_pkg::QUEUE_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_item  = q_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= dec;
      end
   end
endmodule

// ===== hdl/ttl_engine.sv =====
// ----------------------------------------------------------------------------
// ttl_engine
// Executes queued commands on the record table, one slot per cycle,
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module ttl_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  ttl_pkg::item_type             in_item,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [ttl_pkg::RSP_DATA_W-1:0] out_data
);
   localparam int SW = ttl_pkg::SLOT_W;
   localparam int CW = ttl_pkg::COUNT_W;

   logic [ttl_pkg::KEY_W-1:0]  key_ff  [ttl_pkg::ENTRIES];
   logic [ttl_pkg::TTL_W-1:0]  ttl_ff  [ttl_pkg::ENTRIES];
   logic [ttl_pkg::DATA_W-1:0] data_ff [ttl_pkg::ENTRIES];

   ttl_pkg::state_type state_ff, state_in;
   ttl_pkg::item_type  cur_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [SW-1:0] best_ff, best_in;
   logic [SW-1:0] wslot_ff, wslot_in;
   logic          hit_ff, hit_in, ev_ff, ev_in;
   logic [CW-1:0] exp_ff, exp_in;
   logic          ov_ff;
   logic [ttl_pkg::RSP_DATA_W-1:0] od_ff;

   logic [SW-1:0] idx_s, last_s;
   logic          take, at_end, key_eq, fin;
   logic [SW-1:0] out_slot;
   logic [ttl_pkg::TTL_W-1:0]  out_ttl;
   logic [ttl_pkg::DATA_W-1:0] out_dat;

   assign idx_s  = idx_ff[SW-1:0];
   assign last_s = SW'(count_ff - 1'b1);
   assign at_end = (idx_ff >= count_ff);
   assign key_eq = !at_end && (key_ff[idx_s] == cur_ff.key);
   assign in_ready = (state_ff == ttl_pkg::ST_IDLE);
   assign take  = in_valid && in_ready;
   assign fin   = (state_ff == ttl_pkg::ST_DONE) && (!ov_ff || out_ready);
   assign out_valid = ov_ff;
   assign out_data  = od_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ttl_pkg::ST_IDLE:
            if (in_valid) begin
               state_in = (in_item.command == ttl_pkg::CMD_TICK) ?
                          ttl_pkg::ST_TICK_DEC : ttl_pkg::ST_FIND;
            end
         ttl_pkg::ST_FIND:
            if (key_eq) begin
               state_in = (cur_ff.command == ttl_pkg::CMD_INSERT) ?
                          ttl_pkg::ST_WRITE : ttl_pkg::ST_DONE;
            end else if (at_end) begin
               if (cur_ff.command != ttl_pkg::CMD_INSERT) begin
                  state_in = ttl_pkg::ST_DONE;
               end else if (count_ff >= CW'(ttl_pkg::ENTRIES)) begin
                  state_in = ttl_pkg::ST_EVICT_SCAN;
               end else begin
                  state_in = ttl_pkg::ST_WRITE;
               end
            end
         ttl_pkg::ST_TICK_DEC:
            if (at_end) state_in = ttl_pkg::ST_TICK_SWEEP;
         ttl_pkg::ST_TICK_SWEEP:
            if (at_end) state_in = ttl_pkg::ST_DONE;
         ttl_pkg::ST_EVICT_SCAN:
            if (at_end) state_in = ttl_pkg::ST_EVICT_MOVE;
         ttl_pkg::ST_EVICT_MOVE: state_in = ttl_pkg::ST_WRITE;
         ttl_pkg::ST_WRITE:      state_in = ttl_pkg::ST_DONE;
         ttl_pkg::ST_DONE:
            if (!ov_ff || out_ready) state_in = ttl_pkg::ST_IDLE;
         default: state_in = ttl_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in   = idx_ff;
      count_in = count_ff;
      best_in  = best_ff;
      wslot_in = wslot_ff;
      hit_in   = hit_ff;
      ev_in    = ev_ff;
      exp_in   = exp_ff;
      unique case (state_ff)
         ttl_pkg::ST_IDLE: begin
            idx_in = '0;
            best_in = '0;
            hit_in = 1'b0;
            ev_in  = 1'b0;
            exp_in = '0;
         end
         ttl_pkg::ST_FIND:
            if (key_eq) begin
               hit_in = 1'b1;
               wslot_in = idx_s;
            end else if (at_end) begin
               idx_in = CW'(1);
               wslot_in = SW'(count_ff);
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         ttl_pkg::ST_TICK_DEC:
            idx_in = at_end ? '0 : idx_ff + 1'b1;
         ttl_pkg::ST_TICK_SWEEP:
            if (!at_end) begin
               if (ttl_ff[idx_s] == '0) begin
                  count_in = count_ff - 1'b1;
                  exp_in = exp_ff + 1'b1;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         ttl_pkg::ST_EVICT_SCAN:
            if (!at_end) begin
               if (ttl_ff[idx_s] < ttl_ff[best_ff]) best_in = idx_s;
               idx_in = idx_ff + 1'b1;
            end
         ttl_pkg::ST_EVICT_MOVE: begin
            count_in = count_ff - 1'b1;
            wslot_in = last_s;
            ev_in = 1'b1;
         end
         ttl_pkg::ST_WRITE:
            if (!hit_ff) count_in = count_ff + 1'b1;
         ttl_pkg::ST_DONE:
            if (fin && hit_ff && cur_ff.command == ttl_pkg::CMD_REMOVE) begin
               count_in = count_ff - 1'b1;
            end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ttl_pkg::ST_IDLE;
         count_ff <= '0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (fin) begin
            ov_ff <= 1'b1;
         end else if (out_ready) begin
            ov_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      best_ff  <= best_in;
      wslot_ff <= wslot_in;
      hit_ff   <= hit_in;
      ev_ff    <= ev_in;
      exp_ff   <= exp_in;
      if (take) cur_ff <= in_item;
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ttl_pkg::ST_TICK_DEC:
            if (!at_end && ttl_ff[idx_s] != '0) ttl_ff[idx_s] <= ttl_ff[idx_s] - 1'b1;
         ttl_pkg::ST_TICK_SWEEP:
            if (!at_end && ttl_ff[idx_s] == '0) begin
               key_ff[idx_s]  <= key_ff[last_s];
               ttl_ff[idx_s]  <= ttl_ff[last_s];
               data_ff[idx_s] <= data_ff[last_s];
            end
         ttl_pkg::ST_EVICT_MOVE: begin
            key_ff[best_ff]  <= key_ff[last_s];
            ttl_ff[best_ff]  <= ttl_ff[last_s];
            data_ff[best_ff] <= data_ff[last_s];
         end
         ttl_pkg::ST_WRITE: begin
            key_ff[wslot_ff]  <= cur_ff.key;
            ttl_ff[wslot_ff]  <= cur_ff.ttl;
            data_ff[wslot_ff] <= cur_ff.data;
         end
         ttl_pkg::ST_DONE:
            if (fin && hit_ff && cur_ff.command == ttl_pkg::CMD_REMOVE) begin
               key_ff[wslot_ff]  <= key_ff[last_s];
               ttl_ff[wslot_ff]  <= ttl_ff[last_s];
               data_ff[wslot_ff] <= data_ff[last_s];
            end
         default: ;
      endcase
   end

   always_comb begin
      out_slot = '0;
      out_ttl  = '0;
      out_dat  = '0;
      if (cur_ff.command == ttl_pkg::CMD_INSERT) begin
         out_slot = wslot_ff;
         out_ttl  = cur_ff.ttl;
         out_dat  = cur_ff.data;
      end else if (cur_ff.command != ttl_pkg::CMD_TICK && hit_ff) begin
         out_slot = wslot_ff;
         out_ttl  = ttl_ff[wslot_ff];
         out_dat  = data_ff[wslot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (fin) begin
         od_ff <= {3'b000, 4'(exp_ff), ev_ff,
                   4'((hit_ff && cur_ff.command == ttl_pkg::CMD_REMOVE) ?
                      count_ff - 1'b1 : count_ff),
                   out_dat, out_ttl, 3'(out_slot), hit_ff};
      end
   end
endmodule

// ===== hdl/ttl_cache_table_unit.sv =====
// ----------------------------------------------------------------------------
// ttl_cache_table_unit
// TTL cache table: insert, remove, lookup and tick over a dense record table.
//
// channel  dir  fields
// req_     in   tdata: command[1:0] key[65:2] ttl_in[97:66] data_in[129:98]
// rsp_     out  tdata: hit, slot, ttl_out, data_out, occupancy, evicted,
//                      expired_count
// Each item walks the table one slot a cycle; an insert into a full table
// also scans for the smallest TTL to evict, and a tick makes a decrement
// pass and then a sweep pass. A two-item queue lets requests arrive while
// a result waits. Reset clears the record count; no clearing pass.
// ----------------------------------------------------------------------------
module ttl_cache_table_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,   // command, key, ttl_in, data_in
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [79:0]  rsp_tdata    // hit, slot, ttl_out, data_out, occupancy,
                                     // evicted, expired_count
);
   logic              q_valid, q_ready;
   ttl_pkg::item_type q_item;

   ttl_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_data(req_tdata),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   ttl_engine u_engine (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(rsp_tdata)
   );
endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the TTL cache table. Commands stream in with random
// bursts and gaps, results drain under a random stall pattern plus long
// hold-offs, and a scoreboard predicts each result and compares it.
// ----------------------------------------------------------------------------
class ttl_scoreboard;
   logic [63:0] keys [8];
   logic [31:0] ttls [8];
   logic [31:0] datas [8];
   int unsigned count;
   logic [79:0] pending [$];
   int unsigned mismatches;

   function void clear();
      count = 0;
      mismatches = 0;
      pending.delete();
   endfunction

   function int find_slot(logic [63:0] k);
      for (int i = 0; i < count; i++) if (keys[i] == k) return i;
      return -1;
   endfunction

   function void drop_slot(int s);
      int last;
      last = count - 1;
      keys[s] = keys[last];
      ttls[s] = ttls[last];
      datas[s] = datas[last];
      count = last;
   endfunction

   function void note_request(ttl_pkg::item_type it);
      logic hit, ev;
      logic [2:0] slot;
      logic [31:0] tout, dout;
      logic [3:0] expired;
      int f, i, best;
      hit = 0; ev = 0; slot = 0; tout = 0; dout = 0; expired = 0;
      case (it.command)
         ttl_pkg::CMD_INSERT: begin
            f = find_slot(it.key);
            if (f >= 0) begin
               i = f;
               hit = 1;
            end else begin
               if (count >= 8) begin
                  best = 0;
                  for (int j = 1; j < count; j++) if (ttls[j] < ttls[best]) best = j;
                  drop_slot(best);
                  ev = 1;
               end
               i = count;
               count++;
               keys[i] = it.key;
            end
            ttls[i] = it.ttl;
            datas[i] = it.data;
            slot = 3'(i);
            tout = it.ttl;
            dout = it.data;
         end
         ttl_pkg::CMD_REMOVE, ttl_pkg::CMD_LOOKUP: begin
            f = find_slot(it.key);
            if (f >= 0) begin
               hit = 1;
               slot = 3'(f);
               tout = ttls[f];
               dout = datas[f];
               if (it.command == ttl_pkg::CMD_REMOVE) drop_slot(f);
            end
         end
         default: begin
            for (int j = 0; j < count; j++) if (ttls[j] != 0) ttls[j]--;
            i = 0;
            while (i < count) begin
               if (ttls[i] == 0) begin
                  drop_slot(i);
                  expired++;
               end else i++;
            end
         end
      endcase
      pending.push_back({3'b000, expired, ev, 4'(count), dout, tout, slot, hit});
   endfunction

   function void check_result(logic [79:0] got);
      logic [79:0] want;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %h", got);
         return;
      end
      want = pending.pop_front();
      if (got[76:0] !== want[76:0]) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"mismatch: hit %b/%b slot %0d/%0d ttl %h/%h data %h/%h",
                      " occ %0d/%0d ev %b/%b exp %0d/%0d"},
               want[0], got[0], want[3:1], got[3:1], want[35:4], got[35:4],
               want[67:36], got[67:36], want[71:68], got[71:68], want[72], got[72],
               want[76:73], got[76:73]);
      end
   endfunction
endclass

module tb;
   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [79:0]  rsp_tdata;

   ttl_scoreboard table_model = new();
   logic [63:0] key_pool [16];
   bit draining = 0;

   ttl_cache_table_unit uut (.*);

   always #5 clock = ~clock;

   function automatic logic [135:0] pack_item(ttl_pkg::cmd_type c, logic [63:0] k,
                                              logic [31:0] t, logic [31:0] d);
      return {6'd0, d, t, k, c};
   endfunction

   task automatic send_item(ttl_pkg::cmd_type c, logic [63:0] k, logic [31:0] t,
                            logic [31:0] d);
      ttl_pkg::item_type it;
      req_tvalid <= 1;
      req_tdata <= pack_item(c, k, t, d);
      it.command = c; it.key = k; it.ttl = t; it.data = d;
      do @(posedge clock); while (!req_tready);
      table_model.note_request(it);
   endtask

   task automatic pause_sender();
      req_tvalid <= 0;
      repeat ($urandom_range(1, 20)) @(posedge clock);
   endtask

   task automatic random_item();
      ttl_pkg::cmd_type c;
      logic [63:0] k;
      logic [31:0] t;
      int r;
      r = $urandom_range(0, 99);
      c = r < 40 ? ttl_pkg::CMD_INSERT : r < 60 ? ttl_pkg::CMD_REMOVE :
          r < 85 ? ttl_pkg::CMD_LOOKUP : ttl_pkg::CMD_TICK;
      k = $urandom_range(0, 9) == 0 ? {$urandom, $urandom} : key_pool[$urandom_range(0, 15)];
      r = $urandom_range(0, 9);
      t = r < 6 ? $urandom_range(0, 6) : r < 8 ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 3);
      send_item(c, k, t, $urandom);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) table_model.check_result(rsp_tdata);
   end

   initial begin : receiver
      int n;
      int cyc;
      bit held;
      cyc = 0;
      held = 0;
      @(negedge reset);
      forever begin
         if (!draining && ((!held && cyc >= 1000) || $urandom_range(0, 299) == 0)) begin
            held = 1;
            rsp_tready <= 0;
            repeat (200) @(posedge clock);
            cyc += 200;
         end
         n = $urandom_range(0, 3);
         rsp_tready <= (draining || n != 0 || $urandom_range(0, 1));
         @(posedge clock);
         cyc++;
      end
   end

   initial begin : stimulus
      int burst;
      table_model.clear();
      for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = '0;
      key_pool[1] = '1;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_item(ttl_pkg::CMD_LOOKUP, 64'd5, 0, 0);
      send_item(ttl_pkg::CMD_REMOVE, 64'd5, 0, 0);
      send_item(ttl_pkg::CMD_TICK, '0, 0, 0);
      send_item(ttl_pkg::CMD_INSERT, '0, '0, '0);
      send_item(ttl_pkg::CMD_INSERT, '1, '1, '1);
      send_item(ttl_pkg::CMD_INSERT, '1, 32'd3, 32'hA5A5_5A5A);
      for (int i = 2; i < 10; i++)
         send_item(ttl_pkg::CMD_INSERT, key_pool[i], i + 1, $urandom);
      send_item(ttl_pkg::CMD_INSERT, key_pool[12], 32'd2, 32'h1234);
      send_item(ttl_pkg::CMD_LOOKUP, key_pool[12], 0, 0);
      send_item(ttl_pkg::CMD_REMOVE, key_pool[3], 0, 0);
      send_item(ttl_pkg::CMD_LOOKUP, '1, 0, 0);
      send_item(ttl_pkg::CMD_TICK, '0, '1, '1);
      send_item(ttl_pkg::CMD_TICK, '1, 0, 0);
      send_item(ttl_pkg::CMD_TICK, '0, 0, 0);
      pause_sender();
      for (int n = 0; n < 2000; n += burst) begin
         burst = $urandom_range(1, 40);
         for (int j = 0; j < burst; j++) random_item();
         if ($urandom_range(0, 2) != 0) pause_sender();
      end
      req_tvalid <= 0;
      draining = 1;
      while (table_model.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (table_model.mismatches == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
